// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the cache tag model.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked only outside reset
`define SACL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/sacl_pkg.sv =====
// Types and constants of the set-associative LRU cache tag model.
`default_nettype none
package sacl_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] address;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        eviction;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_rsp_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [2:0] ways_in_use;
    logic [5:0] block_bits;
  } geom_t;

  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_STORE  = 2'd1;
  localparam logic [1:0] FN_MODIFY = 2'd2;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam int CFG_ADDR_W  = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_st_t;

endpackage
`default_nettype wire

// ===== rtl/sacl_front.sv =====
// Front end: accepts requests, forms the block address and classifies the access.
`default_nettype none
module sacl_front import sacl_pkg::*; #(
  parameter int ADDR_BITS = 64
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  input  logic [5:0]           block_bits,
  input  logic                 q_full,
  input  logic                 busy,
  output logic                 q_push,
  output logic [ADDR_BITS:0]   q_wdata
);

  logic [ADDR_BITS-1:0] block;
  logic                 dual;
  logic                 keep;

  assign block = in_data.address[ADDR_BITS-1:0] >> block_bits;

  always_comb begin
    dual = 1'b0;
    keep = 1'b1;
    unique case (in_data.func) inside
      FN_LOAD, FN_STORE: dual = 1'b0;
      FN_MODIFY:         dual = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  assign in_stall = q_full | busy;
  assign q_push   = in_valid & ~in_stall & keep;
  assign q_wdata  = {dual, block};

endmodule
`default_nettype wire

// ===== rtl/sacl_queue.sv =====
// Small register queue between the front end and the back end.
`default_nettype none
module sacl_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata    = slot_r[rd_ptr_r];
  assign full     = (count_r == CNT_W'(DEPTH));
  assign nonempty = (count_r != '0);

endmodule
`default_nettype wire

// ===== rtl/sacl_back.sv =====
// Back end: set row read, hit/miss resolution, LRU update, totals and result register.
`default_nettype none
module sacl_back import sacl_pkg::*; #(
  parameter int ADDR_BITS    = 64,
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  geom_t              geom,
  input  logic               q_nonempty,
  input  logic [ADDR_BITS:0] q_rdata,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output out_rsp_t           out_data
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SIDX_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WIDX_W   = AGE_W;
  localparam int WCNT_W   = $clog2(WAYS + 1);

  logic [WAYS-1:0]                 mem_valid [NUM_SETS];
  logic [WAYS-1:0][AGE_W-1:0]      mem_age   [NUM_SETS];
  logic [WAYS-1:0][ADDR_BITS-1:0]  mem_tag   [NUM_SETS];

  logic [WAYS-1:0]                 rd_valid_r;
  logic [WAYS-1:0][AGE_W-1:0]      rd_age_r;
  logic [WAYS-1:0][ADDR_BITS-1:0]  rd_tag_r;

  back_st_t              st_r, st_nxt;
  logic [SIDX_W-1:0]     clr_idx_r;
  logic                  phase_r;
  logic [ADDR_BITS-1:0]  blk_r;
  logic [SIDX_W-1:0]     set_r;
  logic                  last_r;
  logic [31:0]           hit_cnt_r, hit_cnt_nxt;
  logic [31:0]           miss_cnt_r, miss_cnt_nxt;
  logic [31:0]           evict_cnt_r, evict_cnt_nxt;
  logic                  out_valid_r;
  out_rsp_t              out_data_r;

  logic [2:0]            sb_eff;
  logic [WCNT_W-1:0]     nw;
  logic [WAYS-1:0]       in_use;
  logic [SIDX_W-1:0]     set_mask;
  logic [SIDX_W-1:0]     head_set;
  logic [ADDR_BITS-1:0]  q_blk;
  logic                  q_dual;
  logic                  issue_ok;

  logic                  rd_en;
  logic                  wr_en;
  logic                  out_load;
  logic [SIDX_W-1:0]     wr_set;
  logic [WAYS-1:0]       wr_valid;

  logic                  hit;
  logic                  free_found;
  logic                  evict;
  logic [WIDX_W-1:0]     hit_way;
  logic [WIDX_W-1:0]     free_way;
  logic [WIDX_W-1:0]     vic_way;
  logic [WIDX_W-1:0]     fill_way;
  logic [AGE_W-1:0]      max_age;
  logic [AGE_W-1:0]      ref_age;
  logic [WAYS-1:0]                upd_valid;
  logic [WAYS-1:0][AGE_W-1:0]     upd_age;
  logic [WAYS-1:0][ADDR_BITS-1:0] upd_tag;

  // geometry in use
  always_comb begin
    sb_eff = (int'(geom.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : geom.set_bits;
    if (geom.ways_in_use == 3'd0) begin
      nw = WCNT_W'(1);
    end else if (int'(geom.ways_in_use) > WAYS) begin
      nw = WCNT_W'(WAYS);
    end else begin
      nw = WCNT_W'(geom.ways_in_use);
    end
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w < int'(nw));
    end
    for (int i = 0; i < SIDX_W; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
  end

  assign q_blk    = q_rdata[ADDR_BITS-1:0];
  assign q_dual   = q_rdata[ADDR_BITS];
  assign head_set = q_blk[SIDX_W-1:0] & set_mask;
  assign issue_ok = q_nonempty & (~out_valid_r | ~out_stall);

  // lookup on the row read in the previous cycle
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    vic_way    = '0;
    max_age    = rd_age_r[0];
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && rd_valid_r[w] && (rd_tag_r[w] == blk_r) && !hit) begin
        hit     = 1'b1;
        hit_way = WIDX_W'(w);
      end
      if (in_use[w] && !rd_valid_r[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = WIDX_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (rd_age_r[w] > max_age)) begin
        max_age = rd_age_r[w];
        vic_way = WIDX_W'(w);
      end
    end
    ref_age  = rd_age_r[hit_way];
    evict    = ~hit & ~free_found;
    fill_way = free_found ? free_way : vic_way;
  end

  always_comb begin
    upd_valid = rd_valid_r;
    upd_age   = rd_age_r;
    upd_tag   = rd_tag_r;
    if (hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (in_use[w] && rd_valid_r[w] && (rd_age_r[w] < ref_age)) begin
          upd_age[w] = rd_age_r[w] + 1'b1;
        end
      end
      upd_age[hit_way] = '0;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (in_use[w] && rd_valid_r[w] && (rd_age_r[w] < AGE_W'(WAYS - 1))) begin
          upd_age[w] = rd_age_r[w] + 1'b1;
        end
      end
      upd_valid[fill_way] = 1'b1;
      upd_tag[fill_way]   = blk_r;
      upd_age[fill_way]   = '0;
    end
  end

  assign hit_cnt_nxt   = hit_cnt_r + {31'd0, hit};
  assign miss_cnt_nxt  = miss_cnt_r + {31'd0, ~hit};
  assign evict_cnt_nxt = evict_cnt_r + {31'd0, evict};

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_idx_r == SIDX_W'(NUM_SETS - 1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (issue_ok) st_nxt = ST_LOOK;
      ST_LOOK:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    rd_en    = 1'b0;
    q_pop    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    busy     = 1'b0;
    wr_set   = set_r;
    wr_valid = upd_valid;
    unique case (st_r)
      ST_CLEAR: begin
        busy     = 1'b1;
        wr_en    = 1'b1;
        wr_set   = clr_idx_r;
        wr_valid = '0;
      end
      ST_IDLE: begin
        if (issue_ok) begin
          rd_en = 1'b1;
          q_pop = ~q_dual | phase_r;
        end
      end
      ST_LOOK: begin
        wr_en    = 1'b1;
        out_load = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_idx_r   <= '0;
      phase_r     <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (rd_en) begin
        phase_r <= ~q_pop;
      end
      if (out_load) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      blk_r  <= q_blk;
      set_r  <= head_set;
      last_r <= q_pop;
    end
    if (out_load) begin
      out_data_r.hit            <= hit;
      out_data_r.miss           <= ~hit;
      out_data_r.eviction       <= evict;
      out_data_r.last           <= last_r;
      out_data_r.hit_total      <= hit_cnt_nxt;
      out_data_r.miss_total     <= miss_cnt_nxt;
      out_data_r.eviction_total <= evict_cnt_nxt;
    end
  end

  // set row memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_set] <= wr_valid;
      mem_age[wr_set]   <= upd_age;
      mem_tag[wr_set]   <= upd_tag;
    end
    if (rd_en) begin
      rd_valid_r <= mem_valid[head_set];
      rd_age_r   <= mem_age[head_set];
      rd_tag_r   <= mem_tag[head_set];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_lru_sim_core.sv =====
// Top level of the set-associative LRU cache tag model.
//
//  port group   direction  flow control       payload
//  in_*         request in in_valid/in_stall   in_req_t  (func, address)
//  out_*        result out out_valid/out_stall out_rsp_t (flags, totals)
//  APB          config     psel/penable       set_bits, ways_in_use, block_bits
//
//  A load or store is one access and a modify two: each access is one read and one
//  write of a set row in the back end's row memory.
//  After reset the back end clears the valid bits of all 2**MAX_SET_BITS sets
//  (64 by default), one set per cycle, with in_stall high.
//  A stalled result waits in the output register; the queue keeps taking requests until it is full.
//  Unknown func codes are accepted and give no result.
`default_nettype none
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
  parameter int ADDR_BITS    = 64,
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_rsp_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [2:0]          set_bits_r;
  logic [2:0]          ways_r;
  logic [5:0]          block_bits_r;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  geom_t               geom;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_nonempty;
  logic [ADDR_BITS:0]  q_wdata;
  logic [ADDR_BITS:0]  q_rdata;
  logic                busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      ways_r       <= 3'd1;
      block_bits_r <= 6'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SET_BITS:   set_bits_r   <= pwdata[2:0];
        REG_WAYS:       ways_r       <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SET_BITS:   prdata = {29'd0, set_bits_r};
      REG_WAYS:       prdata = {29'd0, ways_r};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits_r};
      default:        prdata = '0;
    endcase
  end

  assign geom = '{set_bits: set_bits_r, ways_in_use: ways_r, block_bits: block_bits_r};

  sacl_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .block_bits(block_bits_r),
    .q_full    (q_full),
    .busy      (busy),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sacl_queue #(
    .WIDTH(ADDR_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rdata   (q_rdata),
    .nonempty(q_nonempty)
  );

  sacl_back #(
    .ADDR_BITS   (ADDR_BITS),
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS        (WAYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .q_nonempty(q_nonempty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/sacl_chk.sv =====
// Port-level checker of the cache tag model and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module sacl_chk import sacl_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_rsp_t              out_data,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  `SACL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `SACL_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `SACL_ASSERT(a_clear_stall, clk, rst_n, $rose(rst_n) |-> in_stall, "request taken during row clear")
  `SACL_ASSERT(a_cfg_readback, clk, rst_n, psel && penable && pwrite && pready && (paddr[3:2] == REG_SET_BITS) ##1 psel && !pwrite && (paddr[3:2] == REG_SET_BITS) |-> prdata[2:0] == $past(pwdata[2:0]), "set_bits readback mismatch")

endmodule

bind set_assoc_cache_lru_sim_core sacl_chk u_sacl_chk (.*);
`default_nettype wire

// ===== verif/set_assoc_cache_lru_sim_core_test.sv =====
// Testbench for the set-associative LRU cache tag model: directed and random requests.
module set_assoc_cache_lru_sim_core_test;
  import sacl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_LOG_MAX  = 6;
  localparam int NUM_WAYS     = 4;
  localparam int NUM_LINES    = (1 << SET_LOG_MAX) * NUM_WAYS;
  localparam int SETTLE       = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int IDLE_PCT     = 35;
  localparam logic [1:0] FN_UNKNOWN = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  set_assoc_cache_lru_sim_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the tag store and registers
  logic        line_v [NUM_LINES];
  logic [63:0] line_t [NUM_LINES];
  logic [1:0]  line_a [NUM_LINES];
  logic [31:0] hit_cnt, miss_cnt, evict_cnt;
  logic [2:0]  set_bits_q, ways_q;
  logic [5:0]  block_bits_q;

  out_rsp_t expected_rsp_q[$];
  int errors = 0;
  int reqs_sent = 0;
  int rsps_seen = 0;
  int phases_run = 0;
  int idle_cycles = 0;
  bit calm = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_sets_log();
    return (set_bits_q > SET_LOG_MAX) ? SET_LOG_MAX : int'(set_bits_q);
  endfunction

  function automatic int eff_ways();
    return (ways_q == 0) ? 1 : ((ways_q > NUM_WAYS) ? NUM_WAYS : int'(ways_q));
  endfunction

  function automatic out_rsp_t cache_access(logic [63:0] blk, logic lst);
    int sb, nw, base, victim, free_way;
    logic h, e;
    logic [1:0] hit_age;
    out_rsp_t r;
    sb = eff_sets_log();
    nw = eff_ways();
    base = int'(blk & ((64'd1 << sb) - 64'd1)) * NUM_WAYS;
    h = 1'b0;
    e = 1'b0;
    free_way = -1;
    for (int w = 0; w < nw; w++) begin
      if (line_v[base + w] && line_t[base + w] == blk) begin
        hit_age = line_a[base + w];
        for (int k = 0; k < nw; k++) begin
          if (line_v[base + k] && line_a[base + k] < hit_age)
            line_a[base + k] = line_a[base + k] + 2'd1;
        end
        line_a[base + w] = 2'd0;
        h = 1'b1;
        hit_cnt = hit_cnt + 32'd1;
        break;
      end
      if (!line_v[base + w] && free_way < 0)
        free_way = w;
    end
    if (!h) begin
      miss_cnt = miss_cnt + 32'd1;
      if (free_way >= 0) begin
        victim = base + free_way;
      end else begin
        victim = base;
        for (int w = 1; w < nw; w++) begin
          if (line_a[base + w] > line_a[victim])
            victim = base + w;
        end
        e = 1'b1;
        evict_cnt = evict_cnt + 32'd1;
      end
      for (int w = 0; w < nw; w++) begin
        if (line_v[base + w] && line_a[base + w] < NUM_WAYS - 1)
          line_a[base + w] = line_a[base + w] + 2'd1;
      end
      line_v[victim] = 1'b1;
      line_t[victim] = blk;
      line_a[victim] = 2'd0;
    end
    r.hit = h;
    r.miss = !h;
    r.eviction = e;
    r.last = lst;
    r.hit_total = hit_cnt;
    r.miss_total = miss_cnt;
    r.eviction_total = evict_cnt;
    return r;
  endfunction

  function automatic void predict_request(in_req_t r);
    logic [63:0] blk;
    blk = r.address >> block_bits_q;
    case (r.func)
      FN_LOAD, FN_STORE: begin
        expected_rsp_q.push_back(cache_access(blk, 1'b1));
      end
      FN_MODIFY: begin
        expected_rsp_q.push_back(cache_access(blk, 1'b0));
        expected_rsp_q.push_back(cache_access(blk, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_req(logic [1:0] fn, logic [63:0] addr);
    in_req_t r;
    r.func = fn;
    r.address = addr;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(r);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [5:0] val, int width);
    logic [31:0] extra;
    extra = $urandom;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = (extra << width) | 32'(val);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SET_BITS:   set_bits_q = val[2:0];
      REG_WAYS:       ways_q = val[2:0];
      REG_BLOCK_BITS: block_bits_q = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_geometry(logic [2:0] sb, logic [2:0] nw, logic [5:0] bb);
    wait_drained();
    cfg_write(REG_SET_BITS, {3'b0, sb}, 3);
    cfg_write(REG_WAYS, {3'b0, nw}, 3);
    cfg_write(REG_BLOCK_BITS, bb, 6);
  endtask

  task automatic test_single_line();
    set_geometry(3'd0, 3'd1, 6'd0);
    send_req(FN_LOAD, 64'd0);
    send_req(FN_LOAD, 64'd0);
    send_req(FN_STORE, 64'd1);
    send_req(FN_MODIFY, 64'd2);
    send_req(FN_UNKNOWN, 64'd2);
    send_req(FN_LOAD, '1);
    send_req(FN_STORE, '1);
    send_req(FN_MODIFY, 64'd0);
  endtask

  task automatic test_lru_and_limits();
    logic [63:0] blk;
    set_geometry(3'd2, 3'd4, 6'd4);
    for (int t = 0; t < 4; t++) begin
      blk = 64'(t) * 4 + 1;
      send_req(FN_LOAD, (blk << 4) | 64'($urandom_range(0, 15)));
    end
    send_req(FN_LOAD, (64'd1 << 4));
    send_req(FN_STORE, ((64'd4 * 4 + 1) << 4));
    send_req(FN_LOAD, ((64'd1 * 4 + 1) << 4) | 64'hf);
    send_req(FN_MODIFY, (64'd1 << 4) | 64'h3);
    // saturated set count, zero ways, widest offset
    set_geometry(3'd7, 3'd0, 6'd63);
    send_req(FN_LOAD, '1);
    send_req(FN_LOAD, 64'd0);
    send_req(FN_MODIFY, 64'h8000_0000_0000_0000);
    set_geometry(3'd7, 3'd7, 6'd32);
    send_req(FN_LOAD, 64'hffff_ffff_0000_0000);
    send_req(FN_STORE, 64'hffff_ffff_1234_5678);
    send_req(FN_UNKNOWN, 64'h0);
  endtask

  task automatic run_random_phase(logic [2:0] sb, logic [2:0] nw, logic [5:0] bb, int count);
    logic [63:0] pool[$];
    logic [63:0] blk, hi, addr;
    int psize, nsets, pick;
    logic [1:0] fn;
    set_geometry(sb, nw, bb);
    phases_run++;
    nsets = 1 << eff_sets_log();
    psize = $urandom_range(2, 3 * eff_ways() + 2);
    for (int i = 0; i < psize; i++) begin
      hi = rand64();
      blk = (hi << eff_sets_log()) | 64'($urandom_range(0, (nsets < 4 ? nsets : 4) - 1));
      pool.push_back(blk & ({64{1'b1}} >> bb));
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      fn = (pick < 40) ? FN_LOAD : (pick < 70) ? FN_STORE : (pick < 95) ? FN_MODIFY : FN_UNKNOWN;
      if ($urandom_range(0, 99) < 85) begin
        blk = pool[$urandom_range(0, pool.size() - 1)];
        addr = (blk << bb) | (rand64() & ((64'd1 << bb) - 64'd1));
      end else begin
        addr = rand64();
      end
      send_req(fn, addr);
    end
  endtask

  task automatic test_random_geometries();
    run_random_phase(3'd0, 3'd1, 6'd0, 100);
    run_random_phase(3'd6, 3'd4, 6'd0, 100);
    run_random_phase(3'd7, 3'd7, 6'd63, 100);
    run_random_phase(3'd1, 3'd0, 6'd32, 100);
    calm = 1;
    run_random_phase(3'd2, 3'd4, 6'd6, 100);
    calm = 0;
    for (int p = 0; p < 9; p++)
      run_random_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 8)), 100);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      rsps_seen++;
      if (expected_rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: %p", out_data);
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_data.hit !== want.hit || out_data.miss !== want.miss ||
            out_data.eviction !== want.eviction || out_data.last !== want.last ||
            out_data.hit_total !== want.hit_total ||
            out_data.miss_total !== want.miss_total ||
            out_data.eviction_total !== want.eviction_total) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_v[i] = 1'b0;
      line_t[i] = '0;
      line_a[i] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    set_bits_q = 3'd0;
    ways_q = 3'd1;
    block_bits_q = 6'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);

    test_single_line();
    test_lru_and_limits();
    test_random_geometries();

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (expected_rsp_q.size() != 0) errors++;
    $display("covered %0d requests and %0d results over %0d random geometries",
             reqs_sent, rsps_seen, phases_run);
    $display("final totals: hits %0d, misses %0d, evictions %0d, errors %0d",
             hit_cnt, miss_cnt, evict_cnt, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_queue.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_sim_core.sv
rtl/sacl_chk.sv
verif/set_assoc_cache_lru_sim_core_test.sv
